// ===== hw/rtl/kvi_pkg.sv =====
// Shared constants, codes and transaction types for the keyframe vec3 interpolator.
package kvi_pkg;

    localparam int MAX_KEYS    = 64;
    localparam int KEY_IDX_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KEY_CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int IN_IDX_W    = 6;
    localparam int KEY_COUNT_W = 7;
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int DIV_Q_W     = VAL_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DIV_Q_W);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_DURATION = 1'b1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [IN_IDX_W-1:0]     key_index;
        logic [VAL_W-1:0]        key_time;
        logic signed [VAL_W-1:0] key_x;
        logic signed [VAL_W-1:0] key_y;
        logic signed [VAL_W-1:0] key_z;
        logic [VAL_W-1:0]        sample_time;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_x;
        logic signed [VAL_W-1:0] out_y;
        logic signed [VAL_W-1:0] out_z;
        logic                    gap_fault;
    } out_item_t;

    typedef struct packed {
        logic [VAL_W-1:0]        key_time;
        logic signed [VAL_W-1:0] key_x;
        logic signed [VAL_W-1:0] key_y;
        logic signed [VAL_W-1:0] key_z;
    } key_entry_t;

    typedef struct packed {
        logic [VAL_W:0] num;
        logic [VAL_W:0] den;
    } div_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] from_val;
        logic signed [VAL_W-1:0] to_val;
    } lerp_req_t;

endpackage

// ===== hw/rtl/kvi_key_ram.sv =====
// Key table memory: one write port, one registered read port.
module kvi_key_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [kvi_pkg::KEY_IDX_W-1:0] waddr,
    input  kvi_pkg::key_entry_t        wdata,
    input  logic [kvi_pkg::KEY_IDX_W-1:0] raddr,
    output kvi_pkg::key_entry_t        rdata
);
    import kvi_pkg::*;

    key_entry_t mem [MAX_KEYS];
    key_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/kvi_divider.sv =====
// Sequential signed divider: (num << 16) / den, one quotient bit per cycle, saturated to 32 bits.
module kvi_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  kvi_pkg::div_req_t              req,
    output logic                           done,
    output logic signed [kvi_pkg::VAL_W-1:0] quot
);
    import kvi_pkg::*;

    typedef enum logic [1:0] {DV_IDLE, DV_ABS, DV_ITER, DV_FIX} dv_state_t;

    localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    dv_state_t              state_reg;
    logic [VAL_W:0]         num_reg;
    logic [VAL_W:0]         den_reg;
    logic [DIV_Q_W-1:0]     dvd_reg;
    logic [VAL_W:0]         dsr_reg;
    logic [VAL_W:0]         rem_reg;
    logic [DIV_Q_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   neg_reg;
    logic                   done_reg;
    logic [VAL_W-1:0]       quot_reg;

    logic [VAL_W:0]         num_abs;
    logic [VAL_W:0]         den_abs;
    logic [VAL_W+1:0]       rem_sh;
    logic [VAL_W+2:0]       diff;
    logic                   pos_ovf;
    logic                   neg_ovf;
    logic [VAL_W-1:0]       sat_val;

    assign num_abs = num_reg[VAL_W] ? ((~num_reg) + 1'b1) : num_reg;
    assign den_abs = den_reg[VAL_W] ? ((~den_reg) + 1'b1) : den_reg;
    assign rem_sh  = {rem_reg, dvd_reg[DIV_Q_W-1]};
    assign diff    = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign pos_ovf = |q_reg[DIV_Q_W-1:VAL_W-1];
    assign neg_ovf = (|q_reg[DIV_Q_W-1:VAL_W]) || (q_reg[VAL_W-1] && (|q_reg[VAL_W-2:0]));

    always_comb
    begin
        if (neg_reg)
        begin
            sat_val = neg_ovf ? SAT_MIN : ((~q_reg[VAL_W-1:0]) + 1'b1);
        end
        else
        begin
            sat_val = pos_ovf ? SAT_MAX : q_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            num_reg   <= '0;
            den_reg   <= '0;
            dvd_reg   <= '0;
            dsr_reg   <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        num_reg   <= req.num;
                        den_reg   <= req.den;
                        state_reg <= DV_ABS;
                    end
                end
                DV_ABS:
                begin
                    dvd_reg   <= {num_abs[VAL_W-1:0], {FRAC_W{1'b0}}};
                    dsr_reg   <= den_abs;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    neg_reg   <= num_reg[VAL_W] ^ den_reg[VAL_W];
                    state_reg <= DV_ITER;
                end
                DV_ITER:
                begin
                    if (!diff[VAL_W+2])
                    begin
                        rem_reg <= diff[VAL_W:0];
                        q_reg   <= {q_reg[DIV_Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[VAL_W:0];
                        q_reg   <= {q_reg[DIV_Q_W-2:0], 1'b0};
                    end
                    dvd_reg <= {dvd_reg[DIV_Q_W-2:0], 1'b0};
                    if (cnt_reg == DIV_CNT_W'(DIV_Q_W - 1))
                    begin
                        state_reg <= DV_FIX;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                DV_FIX:
                begin
                    quot_reg  <= sat_val;
                    done_reg  <= 1'b1;
                    state_reg <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/kvi_lerp.sv =====
// Four-stage blend pipeline: from + round(factor * (to - from) / 2^16), saturated.
module kvi_lerp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  kvi_pkg::lerp_req_t               req,
    input  logic signed [kvi_pkg::VAL_W-1:0] factor,
    output logic                             res_valid,
    output logic signed [kvi_pkg::VAL_W-1:0] res
);
    import kvi_pkg::*;

    localparam int D_W = VAL_W + 1;
    localparam int P_W = VAL_W + D_W;
    localparam int R_W = P_W - FRAC_W;
    localparam int S_W = R_W + 1;
    localparam logic [P_W-1:0] ROUND = P_W'(1) << (FRAC_W - 1);
    localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [D_W-1:0]   d_reg;
    logic signed [P_W-1:0]   p_reg;
    logic [R_W-1:0]          r_reg;
    logic [VAL_W-1:0]        s1_reg, s2_reg, s3_reg;
    logic [VAL_W-1:0]        res_reg;

    logic signed [P_W-1:0]   prod;
    logic [P_W-1:0]          rounded;
    logic [S_W-1:0]          sum;
    logic [S_W-VAL_W:0]      sum_top;
    logic [VAL_W-1:0]        sat_val;

    assign prod    = factor * d_reg;
    assign rounded = p_reg + ROUND;
    assign sum     = {{(S_W-VAL_W){s3_reg[VAL_W-1]}}, s3_reg} + {r_reg[R_W-1], r_reg};
    assign sum_top = sum[S_W-1:VAL_W-1];

    always_comb
    begin
        if ((&sum_top) || !(|sum_top))
        begin
            sat_val = sum[VAL_W-1:0];
        end
        else
        begin
            sat_val = sum[S_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            d_reg   <= '0;
            p_reg   <= '0;
            r_reg   <= '0;
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            res_reg <= '0;
        end
        else
        begin
            v1_reg  <= req_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            d_reg   <= {req.to_val[VAL_W-1], req.to_val} - {req.from_val[VAL_W-1], req.from_val};
            s1_reg  <= req.from_val;
            p_reg   <= prod;
            s2_reg  <= s1_reg;
            r_reg   <= rounded[P_W-1:FRAC_W];
            s3_reg  <= s2_reg;
            res_reg <= sat_val;
        end
    end

    assign res_valid = v4_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/keyframe_vec3_interpolator_unit.sv =====
// Keyframe vec3 interpolator top level: key table, segment search, divide and blend control.
// Key write: taken while idle, the next transaction may follow at once.
// Sample: the key memory scan (one key time per cycle) and the one-bit-per-cycle 48-step
// divider set the time from acceptance to result.
// Single key skips the search, divide and blend; zero gap skips divide and blend. One transaction
// at a time; a finished result waits in the output register while the next transaction is taken.
// Reset: key_count 1, loop_duration 0, no result pending; key table contents undefined.
module keyframe_vec3_interpolator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  kvi_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output kvi_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kvi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kvi_pkg::VAL_W-1:0]        cfg_data
);
    import kvi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK0, ST_CHKL, ST_SCAN, ST_FETCH_S, ST_FETCH_E,
        ST_GAP, ST_GAP2, ST_DIV, ST_LERP, ST_DONE
    } state_t;

    localparam logic [1:0] COMP_X    = 2'd0;
    localparam logic [1:0] COMP_Y    = 2'd1;
    localparam logic [1:0] COMP_Z    = 2'd2;
    localparam logic [1:0] COMP_NONE = 2'd3;

    state_t                 state_reg;
    logic [KEY_COUNT_W-1:0] key_count_reg;
    logic [VAL_W-1:0]       loop_reg;
    logic [VAL_W-1:0]       t_reg;
    logic [KEY_CNT_W-1:0]   n_reg;
    logic                   single_reg;
    logic [KEY_IDX_W-1:0]   i_reg;
    logic [KEY_IDX_W-1:0]   j_reg;
    key_entry_t             start_reg;
    key_entry_t             end_reg;
    logic [VAL_W:0]         gap_reg;
    logic [VAL_W:0]         num_reg;
    logic [1:0]             feed_cnt_reg;
    logic [1:0]             col_cnt_reg;
    out_item_t              res_reg;
    out_item_t              out_data_reg;
    logic                   out_valid_reg;

    logic                   in_accept;
    logic [KEY_CNT_W-1:0]   n_clamp;
    logic [KEY_IDX_W-1:0]   last_idx;
    logic [KEY_IDX_W-1:0]   nx_idx;
    logic [VAL_W:0]         gap_adj;
    logic                   ram_we;
    key_entry_t             ram_wdata;
    logic [KEY_IDX_W-1:0]   ram_raddr;
    key_entry_t             ram_rdata;
    logic                   div_start;
    div_req_t               div_req;
    logic                   div_done;
    logic signed [VAL_W-1:0] div_quot;
    logic                   lerp_valid;
    lerp_req_t              lerp_req;
    logic                   lerp_res_valid;
    logic signed [VAL_W-1:0] lerp_res;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_clamp = KEY_CNT_W'(1);
        end
        else if (int'(key_count_reg) > MAX_KEYS)
        begin
            n_clamp = KEY_CNT_W'(MAX_KEYS);
        end
        else
        begin
            n_clamp = KEY_CNT_W'(key_count_reg);
        end
    end

    assign last_idx = KEY_IDX_W'(n_reg - KEY_CNT_W'(1));
    assign nx_idx   = ((KEY_CNT_W'(i_reg) + KEY_CNT_W'(1)) < n_reg) ?
                      (i_reg + KEY_IDX_W'(1)) : '0;
    assign gap_adj  = gap_reg[VAL_W] ? (gap_reg + {1'b0, loop_reg}) : gap_reg;

    assign ram_we             = in_accept && (in_data.req_type == REQ_WRITE) &&
                                (int'(in_data.key_index) < MAX_KEYS);
    assign ram_wdata.key_time = in_data.key_time;
    assign ram_wdata.key_x    = in_data.key_x;
    assign ram_wdata.key_y    = in_data.key_y;
    assign ram_wdata.key_z    = in_data.key_z;

    always_comb
    begin
        case (state_reg)
            ST_CHK0:    ram_raddr = last_idx;
            ST_CHKL:    ram_raddr = KEY_IDX_W'(1);
            ST_SCAN:    ram_raddr = j_reg + KEY_IDX_W'(1);
            ST_FETCH_S: ram_raddr = i_reg;
            ST_FETCH_E: ram_raddr = nx_idx;
            default:    ram_raddr = '0;
        endcase
    end

    assign div_start   = (state_reg == ST_GAP2) && !single_reg && (gap_adj != '0);
    assign div_req.num = num_reg;
    assign div_req.den = gap_adj;

    assign lerp_valid = (state_reg == ST_LERP) && (feed_cnt_reg != COMP_NONE);

    always_comb
    begin
        case (feed_cnt_reg)
            COMP_X:
            begin
                lerp_req.from_val = start_reg.key_x;
                lerp_req.to_val   = end_reg.key_x;
            end
            COMP_Y:
            begin
                lerp_req.from_val = start_reg.key_y;
                lerp_req.to_val   = end_reg.key_y;
            end
            default:
            begin
                lerp_req.from_val = start_reg.key_z;
                lerp_req.to_val   = end_reg.key_z;
            end
        endcase
    end

    kvi_key_ram u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (KEY_IDX_W'(in_data.key_index)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kvi_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    kvi_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (lerp_valid),
        .req       (lerp_req),
        .factor    (div_quot),
        .res_valid (lerp_res_valid),
        .res       (lerp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KEY_COUNT_W'(1);
            loop_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_COUNT:     key_count_reg <= cfg_data[KEY_COUNT_W-1:0];
                CFG_LOOP_DURATION: loop_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            t_reg         <= '0;
            n_reg         <= KEY_CNT_W'(1);
            single_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            gap_reg       <= '0;
            num_reg       <= '0;
            feed_cnt_reg  <= COMP_NONE;
            col_cnt_reg   <= COMP_X;
            res_reg       <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (in_data.req_type == REQ_SAMPLE))
                    begin
                        t_reg      <= in_data.sample_time;
                        n_reg      <= n_clamp;
                        single_reg <= (n_clamp == KEY_CNT_W'(1));
                        i_reg      <= '0;
                        state_reg  <= (n_clamp == KEY_CNT_W'(1)) ? ST_FETCH_S : ST_CHK0;
                    end
                end
                ST_CHK0:
                begin
                    if (t_reg < ram_rdata.key_time)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_FETCH_S;
                    end
                    else
                    begin
                        state_reg <= ST_CHKL;
                    end
                end
                ST_CHKL:
                begin
                    if (t_reg > ram_rdata.key_time)
                    begin
                        i_reg     <= last_idx;
                        state_reg <= ST_FETCH_S;
                    end
                    else
                    begin
                        j_reg     <= KEY_IDX_W'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (t_reg < ram_rdata.key_time)
                    begin
                        i_reg     <= j_reg - KEY_IDX_W'(1);
                        state_reg <= ST_FETCH_S;
                    end
                    else if (j_reg == last_idx)
                    begin
                        i_reg     <= last_idx;
                        state_reg <= ST_FETCH_S;
                    end
                    else
                    begin
                        j_reg <= j_reg + KEY_IDX_W'(1);
                    end
                end
                ST_FETCH_S:
                begin
                    state_reg <= ST_FETCH_E;
                end
                ST_FETCH_E:
                begin
                    start_reg <= ram_rdata;
                    state_reg <= ST_GAP;
                end
                ST_GAP:
                begin
                    end_reg   <= ram_rdata;
                    gap_reg   <= {1'b0, ram_rdata.key_time} - {1'b0, start_reg.key_time};
                    num_reg   <= {1'b0, t_reg} - {1'b0, start_reg.key_time};
                    state_reg <= ST_GAP2;
                end
                ST_GAP2:
                begin
                    if (single_reg || (gap_adj == '0))
                    begin
                        res_reg.out_x     <= start_reg.key_x;
                        res_reg.out_y     <= start_reg.key_y;
                        res_reg.out_z     <= start_reg.key_z;
                        res_reg.gap_fault <= !single_reg;
                        state_reg         <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        feed_cnt_reg      <= COMP_X;
                        col_cnt_reg       <= COMP_X;
                        res_reg.gap_fault <= 1'b0;
                        state_reg         <= ST_LERP;
                    end
                end
                ST_LERP:
                begin
                    if (feed_cnt_reg != COMP_NONE)
                    begin
                        feed_cnt_reg <= feed_cnt_reg + 2'd1;
                    end
                    if (lerp_res_valid)
                    begin
                        case (col_cnt_reg)
                            COMP_X:  res_reg.out_x <= lerp_res;
                            COMP_Y:  res_reg.out_y <= lerp_res;
                            default: res_reg.out_z <= lerp_res;
                        endcase
                        col_cnt_reg <= col_cnt_reg + 2'd1;
                        if (col_cnt_reg == COMP_Z)
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished while not awaited");

    assert property (@(posedge clk) disable iff (!rst_n)
        lerp_res_valid |-> (state_reg == ST_LERP))
        else $error("blend result outside blend phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (KEY_CNT_W'(j_reg) < n_reg))
        else $error("scan index beyond keys in use");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the keyframe vec3 interpolator: key writes and sample queries.
module tb_top;
    import kvi_pkg::*;

    localparam int SETTLE = 200;
    localparam logic [VAL_W-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] MINV = 32'h8000_0000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_data  = '0;

    key_entry_t             key_tab [MAX_KEYS];
    logic [KEY_COUNT_W-1:0] cur_count = KEY_COUNT_W'(1);
    logic [VAL_W-1:0]       cur_loop  = '0;
    out_item_t              frame_q [$];
    out_item_t              want;
    int                     errors   = 0;
    int                     out_hold = 0;
    bit                     quiet    = 1'b0;

    keyframe_vec3_interpolator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_500_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic int eff_count();
        int n;
        n = int'(cur_count);
        if (n == 0)
            n = 1;
        if (n > MAX_KEYS)
            n = MAX_KEYS;
        return n;
    endfunction

    function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                               longint f);
        longint s, d, r;
        s = longint'($signed(a));
        d = longint'($signed(b)) - s;
        r = s + ((f * d + 64'sd32768) >>> 16);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[VAL_W-1:0];
    endfunction

    function automatic out_item_t predict_sample(logic [VAL_W-1:0] t);
        out_item_t res;
        int        n, i, nx, k;
        longint    gap, num, factor;
        n   = eff_count();
        res = '0;
        if (n == 1)
        begin
            res.out_x = key_tab[0].key_x;
            res.out_y = key_tab[0].key_y;
            res.out_z = key_tab[0].key_z;
            return res;
        end
        if (t < key_tab[0].key_time)
            i = 0;
        else if (t > key_tab[n-1].key_time)
            i = n - 1;
        else
        begin
            i = n - 1;
            for (k = n - 2; k >= 0; k--)
                if (t < key_tab[k+1].key_time)
                    i = k;
        end
        nx  = (i + 1 < n) ? i + 1 : 0;
        gap = longint'(key_tab[nx].key_time) - longint'(key_tab[i].key_time);
        if (gap < 0)
            gap += longint'(cur_loop);
        if (gap == 0)
        begin
            res.out_x     = key_tab[i].key_x;
            res.out_y     = key_tab[i].key_y;
            res.out_z     = key_tab[i].key_z;
            res.gap_fault = 1'b1;
            return res;
        end
        num    = longint'(t) - longint'(key_tab[i].key_time);
        factor = (num * 65536) / gap;
        if (factor > 64'sd2147483647)
            factor = 64'sd2147483647;
        if (factor < -64'sd2147483648)
            factor = -64'sd2147483648;
        res.out_x = blend(key_tab[i].key_x, key_tab[nx].key_x, factor);
        res.out_y = blend(key_tab[i].key_y, key_tab[nx].key_y, factor);
        res.out_z = blend(key_tab[i].key_z, key_tab[nx].key_z, factor);
        return res;
    endfunction

    function automatic in_item_t key_item(int idx, logic [VAL_W-1:0] tm, logic [VAL_W-1:0] x,
                                          logic [VAL_W-1:0] y, logic [VAL_W-1:0] z);
        in_item_t it;
        it.req_type    = REQ_WRITE;
        it.key_index   = IN_IDX_W'(idx);
        it.key_time    = tm;
        it.key_x       = x;
        it.key_y       = y;
        it.key_z       = z;
        it.sample_time = $urandom();
        return it;
    endfunction

    function automatic in_item_t sample_item(logic [VAL_W-1:0] t);
        in_item_t it;
        it.req_type    = REQ_SAMPLE;
        it.key_index   = IN_IDX_W'($urandom());
        it.key_time    = $urandom();
        it.key_x       = $urandom();
        it.key_y       = $urandom();
        it.key_z       = $urandom();
        it.sample_time = t;
        return it;
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        logic [VAL_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 3))
            0: return r;
            1: return r[31] ? MINV : MAXV;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_time();
        int               n, k;
        logic [VAL_W-1:0] lo, hi;
        n = eff_count();
        if (n < 2)
            return $urandom();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2: return key_tab[$urandom_range(0, n - 1)].key_time;
            3: return key_tab[0].key_time - $urandom_range(0, 32'h0002_0000);
            4: return key_tab[n-1].key_time + $urandom_range(0, 32'h0100_0000);
            default:
            begin
                k  = $urandom_range(0, n - 2);
                lo = key_tab[k].key_time;
                hi = key_tab[k+1].key_time;
                if (hi >= lo)
                    return $urandom_range(hi, lo);
                return $urandom();
            end
        endcase
    endfunction

    function automatic in_item_t rand_key_item();
        int               idx;
        logic [VAL_W-1:0] lo, hi, tm;
        idx = $urandom_range(0, MAX_KEYS - 1);
        lo  = (idx > 0) ? key_tab[idx-1].key_time : '0;
        hi  = (idx < MAX_KEYS - 1) ? key_tab[idx+1].key_time : '1;
        if ($urandom_range(0, 9) < 7 && hi >= lo)
            tm = $urandom_range(hi, lo);
        else
            tm = $urandom();
        return key_item(idx, tm, rand_val(), rand_val(), rand_val());
    endfunction

    task automatic send_item(in_item_t it);
        int wait_cyc;
        wait_cyc = quiet ? 0 : $urandom_range(0, 4);
        if (wait_cyc > 0)
        begin
            in_valid <= 1'b0;
            repeat (wait_cyc) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.req_type == REQ_WRITE)
        begin
            key_tab[it.key_index].key_time = it.key_time;
            key_tab[it.key_index].key_x    = it.key_x;
            key_tab[it.key_index].key_y    = it.key_y;
            key_tab[it.key_index].key_z    = it.key_z;
        end
        else
            frame_q = {frame_q, predict_sample(it.sample_time)};
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_COUNT)
            cur_count = val[KEY_COUNT_W-1:0];
        else
            cur_loop = val;
        @(posedge clk);
    endtask

    task automatic set_count(int kc);
        logic [VAL_W-1:0] v;
        v = $urandom();
        v[KEY_COUNT_W-1:0] = KEY_COUNT_W'(kc);
        write_reg(CFG_KEY_COUNT, v);
    endtask

    task automatic check_lane(string name, logic [VAL_W-1:0] want_v, logic [VAL_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s expected %h actual %h", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_q.size() == 0)
            begin
                $error("unexpected result x=%h y=%h z=%h fault=%b",
                       out_data.out_x, out_data.out_y, out_data.out_z, out_data.gap_fault);
                errors++;
            end
            else
            begin
                want = frame_q.pop_front();
                check_lane("out_x", want.out_x, out_data.out_x);
                check_lane("out_y", want.out_y, out_data.out_y);
                check_lane("out_z", want.out_z, out_data.out_z);
                check_lane("gap_fault", 32'(want.gap_fault), 32'(out_data.gap_fault));
            end
            out_hold = quiet ? 0 : $urandom_range(0, 4);
            out_stall <= (out_hold != 0);
        end
        else if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= (out_hold != 0);
        end
    end

    task automatic test_single_key();
        send_item(key_item(0, 32'h0001_0000, MAXV, MINV, 32'h0));
        send_item(sample_item(32'h0));
        send_item(sample_item('1));
        settle();
        set_count(0);
        send_item(sample_item(32'h1234_5678));
    endtask

    task automatic test_zero_gap();
        send_item(key_item(1, 32'h0001_0000, MINV, MAXV, '1));
        settle();
        set_count(2);
        send_item(sample_item(32'h0001_0000));
        send_item(sample_item(32'h0));
    endtask

    task automatic test_segments();
        send_item(key_item(1, 32'h0003_0000, MINV, MAXV, '1));
        send_item(key_item(2, 32'h0005_0000, 32'h1, '1, MAXV));
        send_item(key_item(63, '1, MINV, MAXV, '1));
        settle();
        set_count(3);
        write_reg(CFG_LOOP_DURATION, '0);
        send_item(sample_item(32'h0));
        send_item(sample_item(32'h0002_0000));
        send_item(sample_item(32'h0005_0000));
        send_item(sample_item(32'h0006_0000));
        settle();
        write_reg(CFG_LOOP_DURATION, '1);
        send_item(sample_item(32'h0006_0000));
        send_item(sample_item('1));
    endtask

    task automatic test_unsorted();
        send_item(key_item(0, 32'h0003_0000, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000));
        send_item(key_item(1, 32'h0001_0000, 32'h0004_0000, 32'h0002_0000, MINV));
        send_item(sample_item(32'h0004_0000));
        send_item(sample_item(32'h0002_0000));
    endtask

    task automatic test_fill_table();
        logic [VAL_W-1:0] tm;
        tm = $urandom_range(0, 32'h0010_0000);
        for (int idx = 0; idx < MAX_KEYS; idx++)
        begin
            send_item(key_item(idx, tm, rand_val(), rand_val(), rand_val()));
            tm += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32'h0300_0000);
        end
    endtask

    task automatic test_random_phases();
        int               kc;
        logic [VAL_W-1:0] lp;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    kc = 64;
                    lp = '0;
                end
                1:
                begin
                    kc = 127;
                    lp = '1;
                end
                2:
                begin
                    kc = 2;
                    lp = $urandom();
                end
                3:
                begin
                    kc = 1;
                    lp = $urandom();
                end
                default:
                begin
                    kc = $urandom_range(2, MAX_KEYS);
                    if (ph % 2)
                        lp = $urandom();
                    else
                        lp = key_tab[kc-1].key_time - key_tab[0].key_time
                             + $urandom_range(1, 32'h0100_0000);
                end
            endcase
            settle();
            set_count(kc);
            write_reg(CFG_LOOP_DURATION, lp);
            quiet = (ph == 5);
            for (int j = 0; j < 50; j++)
            begin
                // hold the sender until the block has drained
                if (ph == 6 && j == 25)
                    settle();
                if ($urandom_range(0, 6) == 0)
                    send_item(rand_key_item());
                else
                    send_item(sample_item(rand_time()));
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_key();
        test_zero_gap();
        test_segments();
        test_unsorted();
        test_fill_table();
        test_random_phases();
        settle();
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
